// ----- rtl/pp3s_pkg.sv -----
// Shared types, constants and the sine table generator for the 3D point
// projection block. It depends on nothing; every other file uses it.
package pp3s_pkg;

   localparam int unsigned SCREEN_WIDTH    = 128;
   localparam int unsigned SCREEN_HEIGHT   = 64;
   localparam int unsigned SINE_TABLE_BITS = 10;

   localparam int unsigned COORD_WIDTH     = 32;
   localparam int unsigned ANGLE_WIDTH     = 16;
   localparam int unsigned ZOOM_WIDTH      = 16;
   localparam int unsigned TRIG_WIDTH      = 18;
   localparam int unsigned CSR_INDEX_WIDTH = 8;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CAMERA_X   = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CAMERA_Y   = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CAMERA_Z   = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ANGLE_X    = 8'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ANGLE_Y    = 8'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ANGLE_Z    = 8'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ZOOM       = 8'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PROJ_ENABLE = 8'd7;

   localparam logic [ZOOM_WIDTH-1:0] ZOOM_RESET = 16'd256;

   localparam logic [2:0] TRIG_COS_X = 3'd0;
   localparam logic [2:0] TRIG_SIN_X = 3'd1;
   localparam logic [2:0] TRIG_COS_Y = 3'd2;
   localparam logic [2:0] TRIG_SIN_Y = 3'd3;
   localparam logic [2:0] TRIG_COS_Z = 3'd4;
   localparam logic [2:0] TRIG_SIN_Z = 3'd5;
   localparam logic [2:0] TRIG_DONE  = 3'd6;

   localparam logic [ANGLE_WIDTH-1:0] QUARTER_TURN = 16'h4000;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30     = 64'd1073741824;

   typedef struct packed {
      logic signed [TRIG_WIDTH-1:0] cos_x;
      logic signed [TRIG_WIDTH-1:0] sin_x;
      logic signed [TRIG_WIDTH-1:0] cos_y;
      logic signed [TRIG_WIDTH-1:0] sin_y;
      logic signed [TRIG_WIDTH-1:0] cos_z;
      logic signed [TRIG_WIDTH-1:0] sin_z;
   } pp3s_trig_type;

   // Quarter-wave entry k in Q1.16, from a truncating Q2.30 Taylor series.
   function automatic logic [16:0] sine_entry(input int unsigned k, input int unsigned bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      x  = (longint'(k) * HALF_PI_Q30) >> bits;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 156;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      s  = (s + 64'd8192) >> 14;
      if (s > 64'd65536) begin
         s = 64'd65536;
      end
      return s[16:0];
   endfunction

endpackage

// ----- rtl/pp3s_if.sv -----
// Valid/ready channel interfaces for requests, responses and register writes.
// Depends on pp3s_pkg for field widths.
interface pp3s_req_if;
   logic valid;
   logic ready;
   logic signed [pp3s_pkg::COORD_WIDTH-1:0] point_x;
   logic signed [pp3s_pkg::COORD_WIDTH-1:0] point_y;
   logic signed [pp3s_pkg::COORD_WIDTH-1:0] point_z;
   modport source (output valid, output point_x, output point_y, output point_z, input ready);
   modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface pp3s_rsp_if;
   logic valid;
   logic ready;
   logic signed [pp3s_pkg::COORD_WIDTH-1:0] screen_x;
   logic signed [pp3s_pkg::COORD_WIDTH-1:0] screen_y;
   modport source (output valid, output screen_x, output screen_y, input ready);
   modport sink (input valid, input screen_x, input screen_y, output ready);
endinterface

interface pp3s_csr_if;
   logic valid;
   logic ready;
   logic [pp3s_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [pp3s_pkg::CSR_DATA_WIDTH-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/pp3s_trig.sv -----
// Sine and cosine of the three camera angles, looked up one at a time in
// a quarter-wave ROM after reset and after each angle write. Uses pp3s_pkg.
module pp3s_trig #(
   parameter int unsigned SINE_TABLE_BITS = pp3s_pkg::SINE_TABLE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [pp3s_pkg::ANGLE_WIDTH-1:0]     angle_x,
   input  logic [pp3s_pkg::ANGLE_WIDTH-1:0]     angle_y,
   input  logic [pp3s_pkg::ANGLE_WIDTH-1:0]     angle_z,
   output logic                                 busy,
   output pp3s_pkg::pp3s_trig_type              trig
);

   localparam int unsigned TableSize = (1 << SINE_TABLE_BITS) + 1;
   localparam logic [SINE_TABLE_BITS:0] TableLast = (SINE_TABLE_BITS + 1)'(1 << SINE_TABLE_BITS);

   logic [16:0] sine_rom [TableSize];

   genvar k;
   for (k = 0; k < TableSize; k++) begin : g_rom
      assign sine_rom[k] = pp3s_pkg::sine_entry(k, SINE_TABLE_BITS);
   end

   logic                                busy_ff;
   logic [2:0]                          step_ff;
   logic                                wr_vld_ff;
   logic [2:0]                          wr_sel_ff;
   logic                                wr_neg_ff;
   logic [16:0]                         rom_q_ff;
   pp3s_pkg::pp3s_trig_type             trig_ff;

   logic                                issue_in;
   logic [pp3s_pkg::ANGLE_WIDTH-1:0]    ang_in;
   logic [SINE_TABLE_BITS-1:0]          idx_raw_in;
   logic [SINE_TABLE_BITS:0]            rd_idx_in;
   logic signed [pp3s_pkg::TRIG_WIDTH-1:0] val_in;

   always_comb begin
      issue_in = busy_ff && (step_ff != pp3s_pkg::TRIG_DONE);
      unique case (step_ff)
         pp3s_pkg::TRIG_COS_X: ang_in = angle_x + pp3s_pkg::QUARTER_TURN;
         pp3s_pkg::TRIG_SIN_X: ang_in = angle_x;
         pp3s_pkg::TRIG_COS_Y: ang_in = angle_y + pp3s_pkg::QUARTER_TURN;
         pp3s_pkg::TRIG_SIN_Y: ang_in = angle_y;
         pp3s_pkg::TRIG_COS_Z: ang_in = angle_z + pp3s_pkg::QUARTER_TURN;
         pp3s_pkg::TRIG_SIN_Z: ang_in = angle_z;
         default:              ang_in = angle_x;
      endcase
      idx_raw_in = ang_in[13 -: SINE_TABLE_BITS];
      if (ang_in[14]) begin
         rd_idx_in = TableLast - {1'b0, idx_raw_in};
      end else begin
         rd_idx_in = {1'b0, idx_raw_in};
      end
      if (wr_neg_ff) begin
         val_in = -$signed({1'b0, rom_q_ff});
      end else begin
         val_in = $signed({1'b0, rom_q_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         step_ff   <= pp3s_pkg::TRIG_COS_X;
         wr_vld_ff <= 1'b0;
      end else if (start) begin
         busy_ff   <= 1'b1;
         step_ff   <= pp3s_pkg::TRIG_COS_X;
         wr_vld_ff <= 1'b0;
      end else begin
         wr_vld_ff <= issue_in;
         if (busy_ff) begin
            if (step_ff == pp3s_pkg::TRIG_DONE) begin
               busy_ff <= 1'b0;
            end else begin
               step_ff <= step_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rom_q_ff  <= sine_rom[rd_idx_in];
      wr_sel_ff <= step_ff;
      wr_neg_ff <= ang_in[15];
      if (wr_vld_ff) begin
         unique case (wr_sel_ff)
            pp3s_pkg::TRIG_COS_X: trig_ff.cos_x <= val_in;
            pp3s_pkg::TRIG_SIN_X: trig_ff.sin_x <= val_in;
            pp3s_pkg::TRIG_COS_Y: trig_ff.cos_y <= val_in;
            pp3s_pkg::TRIG_SIN_Y: trig_ff.sin_y <= val_in;
            pp3s_pkg::TRIG_COS_Z: trig_ff.cos_z <= val_in;
            pp3s_pkg::TRIG_SIN_Z: trig_ff.sin_z <= val_in;
            default:              trig_ff       <= trig_ff;
         endcase
      end
   end

   assign busy = busy_ff;
   assign trig = trig_ff;

endmodule

// ----- rtl/point_projection_3d_to_screen_unit.sv -----
// Projects 3D Q16.16 points to screen positions through a ten-stage pipeline.
// Uses pp3s_pkg, the channel interfaces in pp3s_if and pp3s_trig.
//
// One point is accepted per clock while the pipeline is not stalled and no
// coefficient refresh is running, and its screen position leaves from the last
// stage; each stage holds only while the stage after it is full and stalled.
// After reset and after every write to an angle register, the block reads the
// sine ROM six times to refresh the rotation coefficients, and holds off
// requests until that is done.
module point_projection_3d_to_screen_unit #(
   parameter int unsigned SCREEN_WIDTH    = pp3s_pkg::SCREEN_WIDTH,
   parameter int unsigned SCREEN_HEIGHT   = pp3s_pkg::SCREEN_HEIGHT,
   parameter int unsigned SINE_TABLE_BITS = pp3s_pkg::SINE_TABLE_BITS
) (
   input  logic       clock,
   input  logic       reset,
   pp3s_req_if.sink   req_chan,
   pp3s_rsp_if.source rsp_chan,
   pp3s_csr_if.sink   csr_chan
);

   localparam int unsigned LastStage = 9;
   localparam longint CenterXQ24 = longint'(SCREEN_WIDTH / 2) * 64'sd16777216;
   localparam longint CenterYQ24 = longint'(SCREEN_HEIGHT / 2) * 64'sd16777216;

   function automatic logic [31:0] sat32(input logic signed [51:0] v);
      if (v > 52'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end else if (v < -52'sd2147483648) begin
         return 32'h8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

   logic signed [31:0]  camera_x_ff;
   logic signed [31:0]  camera_y_ff;
   logic signed [31:0]  camera_z_ff;
   logic [15:0]         angle_x_ff;
   logic [15:0]         angle_y_ff;
   logic [15:0]         angle_z_ff;
   logic [15:0]         zoom_ff;
   logic                enable_ff;

   logic                csr_write;
   logic                trig_start;
   logic                trig_busy;
   pp3s_pkg::pp3s_trig_type trig;

   assign csr_chan.ready = 1'b1;
   assign csr_write = csr_chan.valid && csr_chan.ready;
   assign trig_start = csr_write && ((csr_chan.index == pp3s_pkg::REG_ANGLE_X)
                                  || (csr_chan.index == pp3s_pkg::REG_ANGLE_Y)
                                  || (csr_chan.index == pp3s_pkg::REG_ANGLE_Z));

   always_ff @(posedge clock) begin
      if (reset) begin
         camera_x_ff <= '0;
         camera_y_ff <= '0;
         camera_z_ff <= '0;
         angle_x_ff  <= '0;
         angle_y_ff  <= '0;
         angle_z_ff  <= '0;
         zoom_ff     <= pp3s_pkg::ZOOM_RESET;
         enable_ff   <= 1'b1;
      end else if (csr_write) begin
         case (csr_chan.index)
            pp3s_pkg::REG_CAMERA_X:    camera_x_ff <= csr_chan.data;
            pp3s_pkg::REG_CAMERA_Y:    camera_y_ff <= csr_chan.data;
            pp3s_pkg::REG_CAMERA_Z:    camera_z_ff <= csr_chan.data;
            pp3s_pkg::REG_ANGLE_X:     angle_x_ff  <= csr_chan.data[15:0];
            pp3s_pkg::REG_ANGLE_Y:     angle_y_ff  <= csr_chan.data[15:0];
            pp3s_pkg::REG_ANGLE_Z:     angle_z_ff  <= csr_chan.data[15:0];
            pp3s_pkg::REG_ZOOM:        zoom_ff     <= csr_chan.data[15:0];
            pp3s_pkg::REG_PROJ_ENABLE: enable_ff   <= csr_chan.data[0];
            default:                   enable_ff   <= enable_ff;
         endcase
      end
   end

   pp3s_trig #(
      .SINE_TABLE_BITS(SINE_TABLE_BITS)
   ) u_trig (
      .clock  (clock),
      .reset  (reset),
      .start  (trig_start),
      .angle_x(angle_x_ff),
      .angle_y(angle_y_ff),
      .angle_z(angle_z_ff),
      .busy   (trig_busy),
      .trig   (trig)
   );

   logic [LastStage:0] vld_ff;
   logic [LastStage:0] move;
   logic               req_take;

   always_comb begin
      move[LastStage] = !vld_ff[LastStage] || rsp_chan.ready;
      for (int i = LastStage - 1; i >= 0; i--) begin
         move[i] = !vld_ff[i] || move[i + 1];
      end
   end

   assign req_chan.ready = move[0] && !trig_busy;
   assign req_take = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (move[0]) begin
            vld_ff[0] <= req_take;
         end
         for (int i = 1; i <= LastStage; i++) begin
            if (move[i]) begin
               vld_ff[i] <= vld_ff[i - 1];
            end
         end
      end
   end

   logic signed [32:0] tx0_ff, ty0_ff, tz0_ff;
   logic signed [50:0] p_ycx_ff, p_zsx_ff, p_ysx_ff, p_zcx_ff;
   logic signed [32:0] tx1_ff;
   logic signed [35:0] ry2_ff, rz2_ff;
   logic signed [32:0] tx2_ff;
   logic signed [53:0] p_xcy_ff, p_zsy_ff;
   logic signed [35:0] ry3_ff;
   logic signed [38:0] rx4_ff;
   logic signed [35:0] ry4_ff;
   logic signed [56:0] p_xcz_ff, p_ysz_ff, p_xsz_ff, p_ycz_ff;
   logic signed [41:0] ox6_ff, oy6_ff;
   logic signed [58:0] zx7_ff, zy7_ff;
   logic signed [51:0] sx8_ff, sy8_ff;
   logic [31:0]        screen_x_ff, screen_y_ff;

   logic signed [32:0] tx0_in, ty0_in, tz0_in;
   logic signed [51:0] ry_sum_in, rz_sum_in;
   logic signed [54:0] rx_sum_in;
   logic signed [57:0] ox_sum_in, oy_sum_in;
   logic signed [59:0] sx_sum_in, sy_sum_in;
   logic signed [16:0] zoom_in;

   always_comb begin
      tx0_in    = 33'(req_chan.point_x) - 33'(camera_x_ff);
      ty0_in    = 33'(req_chan.point_y) - 33'(camera_y_ff);
      tz0_in    = 33'(req_chan.point_z) - 33'(camera_z_ff);
      ry_sum_in = 52'(p_ycx_ff) - 52'(p_zsx_ff) + 52'sd32768;
      rz_sum_in = 52'(p_ysx_ff) + 52'(p_zcx_ff) + 52'sd32768;
      rx_sum_in = 55'(p_xcy_ff) + 55'(p_zsy_ff) + 55'sd32768;
      ox_sum_in = 58'(p_xcz_ff) - 58'(p_ysz_ff) + 58'sd32768;
      oy_sum_in = 58'(p_xsz_ff) + 58'(p_ycz_ff) + 58'sd32768;
      zoom_in   = $signed({1'b0, zoom_ff});
      sx_sum_in = 60'(zx7_ff) + 60'(CenterXQ24) + 60'sd128;
      sy_sum_in = 60'(CenterYQ24) - 60'(zy7_ff) + 60'sd127;
   end

   always_ff @(posedge clock) begin
      if (move[0]) begin
         tx0_ff <= tx0_in;
         ty0_ff <= ty0_in;
         tz0_ff <= tz0_in;
      end
      if (move[1]) begin
         p_ycx_ff <= ty0_ff * trig.cos_x;
         p_zsx_ff <= tz0_ff * trig.sin_x;
         p_ysx_ff <= ty0_ff * trig.sin_x;
         p_zcx_ff <= tz0_ff * trig.cos_x;
         tx1_ff   <= tx0_ff;
      end
      if (move[2]) begin
         ry2_ff <= ry_sum_in[51:16];
         rz2_ff <= rz_sum_in[51:16];
         tx2_ff <= tx1_ff;
      end
      if (move[3]) begin
         p_xcy_ff <= tx2_ff * trig.cos_y;
         p_zsy_ff <= rz2_ff * trig.sin_y;
         ry3_ff   <= ry2_ff;
      end
      if (move[4]) begin
         rx4_ff <= rx_sum_in[54:16];
         ry4_ff <= ry3_ff;
      end
      if (move[5]) begin
         p_xcz_ff <= rx4_ff * trig.cos_z;
         p_ysz_ff <= ry4_ff * trig.sin_z;
         p_xsz_ff <= rx4_ff * trig.sin_z;
         p_ycz_ff <= ry4_ff * trig.cos_z;
      end
      if (move[6]) begin
         ox6_ff <= ox_sum_in[57:16];
         oy6_ff <= oy_sum_in[57:16];
      end
      if (move[7]) begin
         zx7_ff <= ox6_ff * zoom_in;
         zy7_ff <= oy6_ff * zoom_in;
      end
      if (move[8]) begin
         sx8_ff <= sx_sum_in[59:8];
         sy8_ff <= sy_sum_in[59:8];
      end
      if (move[9]) begin
         if (enable_ff) begin
            screen_x_ff <= sat32(sx8_ff);
            screen_y_ff <= sat32(sy8_ff);
         end else begin
            screen_x_ff <= '0;
            screen_y_ff <= '0;
         end
      end
   end

   assign rsp_chan.valid    = vld_ff[LastStage];
   assign rsp_chan.screen_x = screen_x_ff;
   assign rsp_chan.screen_y = screen_y_ff;

endmodule

// ----- rtl/pp3s_checker.sv -----
// Port-level checks for the projection unit, bound to its top level.
// Depends on pp3s_pkg and sees only the top level's channel signals.
module pp3s_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] screen_x,
   input logic [31:0] screen_y,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [pp3s_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input logic [pp3s_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   logic [4:0] pending_ff;
   logic       enable_ff;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         enable_ff  <= 1'b1;
      end else begin
         pending_ff <= pending_ff + 5'(req_fire) - 5'(rsp_fire);
         if (csr_valid && csr_ready && (csr_index == pp3s_pkg::REG_PROJ_ENABLE)) begin
            enable_ff <= csr_data[0];
         end
      end
   end

   a_no_invented_response: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 5'd0))
      else $error("response shown with no request outstanding");

   a_bounded_inflight: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 5'd10)
      else $error("more requests in flight than pipeline stages");

   a_disabled_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !enable_ff) |-> ((screen_x == 32'd0) && (screen_y == 32'd0)))
      else $error("nonzero response while projection is disabled");

   a_response_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(screen_x) && $stable(screen_y)))
      else $error("stalled response changed or dropped");

endmodule

bind point_projection_3d_to_screen_unit pp3s_checker u_pp3s_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .screen_x (rsp_chan.screen_x),
   .screen_y (rsp_chan.screen_y),
   .csr_valid(csr_chan.valid),
   .csr_ready(csr_chan.ready),
   .csr_index(csr_chan.index),
   .csr_data (csr_chan.data)
);

// ----- test/point_projection_3d_to_screen_unit_checker.sv -----
`timescale 1ns / 100ps
// Checker for the 3D point projection block: it tracks register writes, predicts
// each screen position from the accepted requests and compares the responses.
// Depends on pp3s_pkg and the channel interfaces in pp3s_if.
module point_projection_3d_to_screen_unit_checker
   import pp3s_pkg::*;
(
   input  logic clock,
   input  logic reset,
   pp3s_req_if  req_mon,
   pp3s_rsp_if  rsp_mon,
   pp3s_csr_if  csr_mon,
   output int   mismatch_count,
   output int   outstanding,
   output int   checked_count
);

   localparam int unsigned TABLE_STEPS   = 1 << SINE_TABLE_BITS;
   localparam longint unsigned HALF_PI_FIXED = 64'd1686629713;
   localparam longint unsigned UNIT_Q30  = 64'd1 << 30;
   localparam longint CENTRE_X  = longint'(SCREEN_WIDTH / 2) <<< 16;
   localparam longint CENTRE_Y  = longint'(SCREEN_HEIGHT / 2) <<< 16;
   localparam longint Q16_MAX   = 64'sd2147483647;
   localparam longint Q16_MIN   = -64'sd2147483648;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] screen_x;
      logic [COORD_WIDTH-1:0] screen_y;
   } screen_pos_t;

   longint      quarter_sine [0:TABLE_STEPS];
   screen_pos_t expected_screens [$];

   logic signed [COORD_WIDTH-1:0] cam_x, cam_y, cam_z;
   logic [ANGLE_WIDTH-1:0]        turn_x, turn_y, turn_z;
   logic [ZOOM_WIDTH-1:0]         zoom_q8_8;
   logic                          projecting;

   function automatic longint quarter_wave_entry(input int unsigned k);
      longint unsigned divisors [6];
      longint unsigned ang;
      longint unsigned ang_sq;
      longint unsigned term;
      longint unsigned value;
      divisors = '{156, 110, 72, 42, 20, 6};
      ang      = (longint'(k) * HALF_PI_FIXED) >> SINE_TABLE_BITS;
      ang_sq   = (ang * ang) >> 30;
      term     = UNIT_Q30;
      for (int i = 0; i < 6; i++) begin
         term = UNIT_Q30 - ((ang_sq * term) >> 30) / divisors[i];
      end
      value = (ang * term) >> 30;
      value = (value + 64'd8192) >> 14;
      if (value > 64'd65536) begin
         value = 64'd65536;
      end
      return longint'(value);
   endfunction

   initial begin
      for (int k = 0; k <= TABLE_STEPS; k++) begin
         quarter_sine[k] = quarter_wave_entry(k);
      end
   end

   function automatic longint sine_of(input logic [ANGLE_WIDTH-1:0] a);
      logic [1:0]  quadrant;
      int unsigned slot;
      quadrant = a[15:14];
      slot     = int'(a[13:0]) >> (14 - SINE_TABLE_BITS);
      if (quadrant[0]) begin
         slot = TABLE_STEPS - slot;
      end
      return quadrant[1] ? -quarter_sine[slot] : quarter_sine[slot];
   endfunction

   function automatic longint cosine_of(input logic [ANGLE_WIDTH-1:0] a);
      logic [ANGLE_WIDTH-1:0] shifted;
      shifted = a + QUARTER_TURN;
      return sine_of(shifted);
   endfunction

   function automatic longint round_half_up(input longint v, input int unsigned n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic logic [COORD_WIDTH-1:0] clamp_q16(input longint v);
      if (v > Q16_MAX) begin
         return 32'h7FFF_FFFF;
      end
      if (v < Q16_MIN) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic screen_pos_t project_point(input logic signed [COORD_WIDTH-1:0] px,
                                                 input logic signed [COORD_WIDTH-1:0] py,
                                                 input logic signed [COORD_WIDTH-1:0] pz);
      screen_pos_t pos;
      longint dx, dy, dz;
      longint cos_x, sin_x, cos_y, sin_y, cos_z, sin_z;
      longint ry, rz, rx2, rx3, ry3;
      pos = '0;
      if (projecting) begin
         dx    = longint'(px) - longint'(cam_x);
         dy    = longint'(py) - longint'(cam_y);
         dz    = longint'(pz) - longint'(cam_z);
         cos_x = cosine_of(turn_x);
         sin_x = sine_of(turn_x);
         cos_y = cosine_of(turn_y);
         sin_y = sine_of(turn_y);
         cos_z = cosine_of(turn_z);
         sin_z = sine_of(turn_z);
         ry    = round_half_up(dy * cos_x - dz * sin_x, 16);
         rz    = round_half_up(dy * sin_x + dz * cos_x, 16);
         rx2   = round_half_up(dx * cos_y + rz * sin_y, 16);
         rx3   = round_half_up(rx2 * cos_z - ry * sin_z, 16);
         ry3   = round_half_up(rx2 * sin_z + ry * cos_z, 16);
         rx3   = round_half_up(rx3 * longint'(zoom_q8_8), 8);
         ry3   = round_half_up(ry3 * longint'(zoom_q8_8), 8);
         pos.screen_x = clamp_q16(CENTRE_X + rx3);
         pos.screen_y = clamp_q16(CENTRE_Y - ry3);
      end
      return pos;
   endfunction

   function automatic void apply_register_write(input logic [CSR_INDEX_WIDTH-1:0] index,
                                                input logic [CSR_DATA_WIDTH-1:0] data);
      case (index)
         REG_CAMERA_X:    cam_x = data;
         REG_CAMERA_Y:    cam_y = data;
         REG_CAMERA_Z:    cam_z = data;
         REG_ANGLE_X:     turn_x = data[15:0];
         REG_ANGLE_Y:     turn_y = data[15:0];
         REG_ANGLE_Z:     turn_z = data[15:0];
         REG_ZOOM:        zoom_q8_8 = data[15:0];
         REG_PROJ_ENABLE: projecting = data[0];
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      screen_pos_t observed;
      screen_pos_t predicted;
      if (reset) begin
         cam_x      = '0;
         cam_y      = '0;
         cam_z      = '0;
         turn_x     = '0;
         turn_y     = '0;
         turn_z     = '0;
         zoom_q8_8  = ZOOM_RESET;
         projecting = 1'b1;
         expected_screens.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            apply_register_write(csr_mon.index, csr_mon.data);
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_screens.push_back(project_point(req_mon.point_x, req_mon.point_y,
                                                     req_mon.point_z));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            observed = {rsp_mon.screen_x, rsp_mon.screen_y};
            checked_count++;
            if (expected_screens.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: response x=%h y=%h arrived with no request pending",
                           $time, observed.screen_x, observed.screen_y);
               end
            end else begin
               predicted = expected_screens.pop_front();
               if (observed.screen_x !== predicted.screen_x ||
                   observed.screen_y !== predicted.screen_y) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: screen mismatch, expected x=%h y=%h, got x=%h y=%h",
                              $time, predicted.screen_x, predicted.screen_y,
                              observed.screen_x, observed.screen_y);
                  end
               end
            end
         end
      end
      outstanding = expected_screens.size();
   end

endmodule

// ----- test/point_projection_3d_to_screen_unit_test.sv -----
`timescale 1ns / 100ps
// Top of the testbench for point_projection_3d_to_screen_unit: clock, reset,
// register and request stimulus, response stalls and the verdict.
// Depends on pp3s_pkg, pp3s_if, the block and the projection checker module.
module point_projection_3d_to_screen_unit_test;
   import pp3s_pkg::*;

   localparam logic [COORD_WIDTH-1:0] EXTREME_COORDS [4] =
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
   localparam logic [CSR_INDEX_WIDTH-1:0] CAMERA_REGS [3] =
      '{REG_CAMERA_X, REG_CAMERA_Y, REG_CAMERA_Z};
   localparam logic [CSR_INDEX_WIDTH-1:0] ANGLE_REGS [3] =
      '{REG_ANGLE_X, REG_ANGLE_Y, REG_ANGLE_Z};

   logic clock;
   logic reset;
   int   mismatch_count;
   int   outstanding;
   int   checked_count;
   int   points_sent;
   int   settings_used;
   bit   req_idling;
   bit   rsp_stalling;
   logic [COORD_WIDTH-1:0] camera_pos [3];

   pp3s_req_if req_chan ();
   pp3s_rsp_if rsp_chan ();
   pp3s_csr_if csr_chan ();

   point_projection_3d_to_screen_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   point_projection_3d_to_screen_unit_checker projection_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_mon        (csr_chan),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .checked_count  (checked_count)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #20_000_000;
      $display("point_projection_3d_to_screen_unit_test: FAIL");
      $finish;
   end

   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
         return $urandom_range(1, 3);
      end else if (roll < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   initial begin
      int hold;
      hold = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            hold--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (rsp_stalling && $urandom_range(0, 3) == 0) begin
               hold = idle_length();
            end
         end
      end
   end

   task automatic send_point(input logic [COORD_WIDTH-1:0] px,
                             input logic [COORD_WIDTH-1:0] py,
                             input logic [COORD_WIDTH-1:0] pz);
      int gap;
      if (req_idling && $urandom_range(0, 2) == 0) begin
         gap = idle_length();
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.point_x <= px;
      req_chan.point_y <= py;
      req_chan.point_z <= pz;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      points_sent++;
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
   endtask

   task automatic wait_until_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [COORD_WIDTH-1:0] random_coord(input logic [COORD_WIDTH-1:0] anchor);
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return anchor + {{8{r[23]}}, r[23:0]};
         5, 6, 7:       return r;
         8:             return EXTREME_COORDS[r[1:0]];
         default:       return {{12{r[19]}}, r[19:0]};
      endcase
   endfunction

   task automatic configure_random();
      logic [31:0] r;
      for (int axis = 0; axis < 3; axis++) begin
         if ($urandom_range(0, 2) != 0) begin
            r = $urandom();
            case ($urandom_range(0, 4))
               0: r = '0;
               1: r = {{8{r[23]}}, r[23:0]};
               2: r = EXTREME_COORDS[r[1:0]];
               default: ;
            endcase
            write_register(CAMERA_REGS[axis], r);
            camera_pos[axis] = r;
         end
      end
      for (int axis = 0; axis < 3; axis++) begin
         if ($urandom_range(0, 2) != 0) begin
            r = $urandom();
            case ($urandom_range(0, 5))
               0: r[15:0] = '0;
               1: r[15:0] = {r[1:0], 14'd0};
               2: r[15:0] = 16'hFFFF;
               default: ;
            endcase
            write_register(ANGLE_REGS[axis], r);
         end
      end
      if ($urandom_range(0, 1) != 0) begin
         r = $urandom();
         case ($urandom_range(0, 4))
            0: r[15:0] = '0;
            1: r[15:0] = 16'hFFFF;
            2: r[15:0] = ZOOM_RESET;
            3: r[15:0] = {6'd0, r[9:0]};
            default: ;
         endcase
         write_register(REG_ZOOM, r);
      end
      r    = $urandom();
      r[0] = ($urandom_range(0, 5) != 0);
      write_register(REG_PROJ_ENABLE, r);
      if ($urandom_range(0, 3) == 0) begin
         write_register(CSR_INDEX_WIDTH'($urandom_range(8, 255)), $urandom());
      end
      csr_chan.valid <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int random_points;
      int phase_points;
      req_chan.valid   <= 1'b0;
      req_chan.point_x <= '0;
      req_chan.point_y <= '0;
      req_chan.point_z <= '0;
      csr_chan.valid   <= 1'b0;
      csr_chan.index   <= '0;
      csr_chan.data    <= '0;
      reset            <= 1'b1;
      camera_pos       = '{default: '0};
      req_idling       = 1'b0;
      rsp_stalling     = 1'b0;
      points_sent      = 0;
      settings_used    = 1;
      random_points    = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001);

      wait_until_drained();
      write_register(REG_CAMERA_X, 32'h8000_0000);
      write_register(REG_CAMERA_Y, 32'h7FFF_FFFF);
      write_register(REG_CAMERA_Z, 32'h1234_5678);
      write_register(REG_ANGLE_X, 32'hABCD_2000);
      write_register(REG_ANGLE_Y, 32'h0000_6000);
      write_register(REG_ANGLE_Z, 32'h0000_FFFF);
      write_register(REG_ZOOM, 32'h5A5A_FFFF);
      write_register(REG_PROJ_ENABLE, 32'hFFFF_FFFF);
      csr_chan.valid <= 1'b0;
      settings_used++;
      req_idling   = 1'b1;
      rsp_stalling = 1'b1;
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
      send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);

      wait_until_drained();
      write_register(REG_CAMERA_X, 32'h0000_0000);
      write_register(REG_CAMERA_Y, 32'h0000_0000);
      write_register(REG_CAMERA_Z, 32'h0000_0000);
      write_register(REG_ANGLE_X, 32'h0000_4000);
      write_register(REG_ANGLE_Y, 32'h0000_8000);
      write_register(REG_ANGLE_Z, 32'h0000_C000);
      write_register(REG_ZOOM, 32'h0000_0000);
      csr_chan.valid <= 1'b0;
      settings_used++;
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h0003_0000, 32'hFFFE_0000, 32'h0001_0000);
      send_point(32'h8000_0000, 32'h0000_0000, 32'h8000_0000);

      wait_until_drained();
      write_register(REG_PROJ_ENABLE, 32'hFFFF_FFFE);
      write_register(CSR_INDEX_WIDTH'(8), 32'hFFFF_FFFF);
      write_register(CSR_INDEX_WIDTH'(255), 32'h0000_0001);
      csr_chan.valid <= 1'b0;
      settings_used++;
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
      send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_point(32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000);

      wait_until_drained();
      write_register(REG_PROJ_ENABLE, 32'h0000_0001);
      write_register(REG_ZOOM, 32'h0000_0080);
      write_register(REG_ANGLE_X, 32'h0000_0001);
      write_register(REG_ANGLE_Y, 32'h0000_3FFF);
      write_register(REG_ANGLE_Z, 32'h0000_7FF0);
      csr_chan.valid <= 1'b0;
      settings_used++;
      send_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
      send_point(32'hFFFF_8000, 32'hFFFF_7FFF, 32'h0000_8001);
      send_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003);
      send_point(32'h0040_0000, 32'hFFC0_0000, 32'h0020_0000);

      while (random_points < 1750) begin
         wait_until_drained();
         configure_random();
         req_idling   = ($urandom_range(0, 3) != 0);
         rsp_stalling = ($urandom_range(0, 3) != 0);
         phase_points = $urandom_range(90, 160);
         repeat (phase_points) begin
            send_point(random_coord(camera_pos[0]), random_coord(camera_pos[1]),
                       random_coord(camera_pos[2]));
         end
         random_points += phase_points;
      end

      wait_until_drained();
      repeat (20) @(posedge clock);
      $display("Sent %0d points under %0d register settings; %0d responses checked, %0d bad.",
               points_sent, settings_used, checked_count, mismatch_count);
      $display("Settings spanned extreme camera offsets and angles, zero to full zoom and disabled projection.");
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("point_projection_3d_to_screen_unit_test: PASS");
      end else begin
         $display("point_projection_3d_to_screen_unit_test: FAIL");
      end
      $finish;
   end

endmodule

// ----- point_projection_3d_to_screen_unit.f -----
rtl/pp3s_pkg.sv
rtl/pp3s_if.sv
rtl/pp3s_trig.sv
rtl/point_projection_3d_to_screen_unit.sv
rtl/pp3s_checker.sv
test/point_projection_3d_to_screen_unit_checker.sv
test/point_projection_3d_to_screen_unit_test.sv
